// ----- src/fisa_pkg.sv -----
package fisa_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int HEAD_W     = 11;
    localparam int HANDLE_W   = 16;
    localparam int STRIDE_W   = 16;
    localparam int OFFSET_W   = 32;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HANDLE_W-1:0] INVALID_HANDLE = '1;

    localparam logic [OP_W-1:0] OP_OBTAIN   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE_ALL = 2'd2;
    localparam logic [OP_W-1:0] OP_ACCESS   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_STRIDE = 2'd1;

    localparam logic [HEAD_W-1:0] POOL_ENTRIES_RESET = HEAD_W'(1024);
    localparam logic [STRIDE_W-1:0] ENTRY_STRIDE_RESET = STRIDE_W'(1);

    // Outcome of one operation as decided from the head and the fill mark.
    typedef struct packed {
        logic                pop;     // obtain that takes an entry
        logic                fresh;   // popped entry never rewritten since refill
        logic [STATUS_W-1:0] status;
        logic [HEAD_W-1:0]   count;   // handles outstanding afterwards
    } dec_t;

endpackage

// ----- src/fisa_stack_ram.sv -----
module fisa_stack_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [fisa_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [fisa_pkg::HANDLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [fisa_pkg::ADDR_W-1:0]   rd_addr,
    output logic [fisa_pkg::HANDLE_W-1:0] rd_data
);

    logic [fisa_pkg::HANDLE_W-1:0] mem [fisa_pkg::POOL_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read word holds until the next enabled read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/fisa_head_ctrl.sv -----
module fisa_head_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [fisa_pkg::OP_W-1:0]     op,
    input  logic [fisa_pkg::HEAD_W-1:0]   pool_entries,
    output logic [fisa_pkg::ADDR_W-1:0]   rd_addr,
    output logic                          wr_en,
    output logic [fisa_pkg::ADDR_W-1:0]   wr_addr,
    output fisa_pkg::dec_t                dec
);

    logic [fisa_pkg::HEAD_W-1:0] head_reg, head_next;
    // Fill mark: highest head reached since the last refill. An entry at or
    // above it still holds its own index; below it the memory is current.
    logic [fisa_pkg::HEAD_W-1:0] hwm_reg, hwm_next;
    logic [fisa_pkg::HEAD_W-1:0] pool_eff;

    assign pool_eff = (pool_entries > fisa_pkg::HEAD_W'(fisa_pkg::POOL_DEPTH))
                    ? fisa_pkg::HEAD_W'(fisa_pkg::POOL_DEPTH) : pool_entries;

    assign rd_addr = head_reg[fisa_pkg::ADDR_W-1:0];
    assign wr_addr = fisa_pkg::ADDR_W'(head_reg - fisa_pkg::HEAD_W'(1));
    assign wr_en   = accept && (op == fisa_pkg::OP_RELEASE) && (head_reg != '0);

    always_comb begin
        head_next  = head_reg;
        hwm_next   = hwm_reg;
        dec.pop    = 1'b0;
        dec.fresh  = (head_reg == hwm_reg);
        dec.status = fisa_pkg::STATUS_OK;
        case (op)
            fisa_pkg::OP_OBTAIN: begin
                if (head_reg < pool_eff) begin
                    dec.pop   = 1'b1;
                    head_next = head_reg + fisa_pkg::HEAD_W'(1);
                    if (head_reg == hwm_reg) begin
                        hwm_next = head_next;
                    end
                end else begin
                    dec.status = fisa_pkg::STATUS_EMPTY;
                end
            end
            fisa_pkg::OP_RELEASE: begin
                if (head_reg == '0) begin
                    dec.status = fisa_pkg::STATUS_UNDERFLOW;
                end else begin
                    head_next = head_reg - fisa_pkg::HEAD_W'(1);
                end
            end
            fisa_pkg::OP_FREE_ALL: begin
                head_next = '0;
                hwm_next  = '0;
            end
            default: begin
            end
        endcase
        dec.count = head_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            hwm_reg  <= '0;
        end else if (accept) begin
            head_reg <= head_next;
            hwm_reg  <= hwm_next;
        end
    end

endmodule

// ----- src/free_index_stack_allocator.sv -----
// Handle allocator that keeps its free handles as a stack in a 1024 x 16
// synchronous memory.
// Input channel (s_valid/s_ready): s_operation selects obtain, release,
// free all or access; s_handle is the handle to release or to access.
// Result channel (m_valid/m_ready): exactly one item per input item, in
// order, with the granted handle, the byte offset of an access, the status
// and the number of handles in use afterwards.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 sets
// the pool size, index 1 the stride in bytes; other indexes are ignored.
// Write it only while no item is in flight.
// An accepted item is captured together with its stack memory read; the result
// is formed from them in the execute state and loaded into the output register
// once that is free. One item is in flight at a time.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls, that next item holds in the execute
// state and s_ready stays low until the output register frees up.
// Reset is synchronous and immediate: the head and the fill mark clear, so
// the stack reads as entry i holding i without any clearing pass.
module free_index_stack_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fisa_pkg::OP_W-1:0]       s_operation,
    input  logic [fisa_pkg::HANDLE_W-1:0]   s_handle,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fisa_pkg::HANDLE_W-1:0]   m_granted_handle,
    output logic [fisa_pkg::OFFSET_W-1:0]   m_byte_offset,
    output logic                            m_offset_valid,
    output logic [fisa_pkg::STATUS_W-1:0]   m_status,
    output logic [fisa_pkg::HEAD_W-1:0]     m_in_use_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fisa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fisa_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic accept;
    logic out_load;

    // Configuration registers.
    logic [fisa_pkg::HEAD_W-1:0]   pool_entries_reg;
    logic [fisa_pkg::STRIDE_W-1:0] entry_stride_reg;

    // Item held between acceptance and result.
    logic [fisa_pkg::OP_W-1:0]     op_reg;
    logic                          handle_ok_reg;
    logic [fisa_pkg::OFFSET_W-1:0] prod_reg;
    logic [fisa_pkg::ADDR_W-1:0]   idx_reg;
    fisa_pkg::dec_t                dec_reg;

    // Output register.
    logic                          m_valid_reg;
    logic [fisa_pkg::HANDLE_W-1:0] granted_reg, granted_next;
    logic [fisa_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic                          ovalid_reg, ovalid_next;
    logic [fisa_pkg::STATUS_W-1:0] status_reg;
    logic [fisa_pkg::HEAD_W-1:0]   count_reg;

    logic [fisa_pkg::ADDR_W-1:0]   rd_addr;
    logic [fisa_pkg::ADDR_W-1:0]   wr_addr;
    logic                          wr_en;
    logic [fisa_pkg::HANDLE_W-1:0] rd_data;
    fisa_pkg::dec_t                dec;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    fisa_head_ctrl u_head (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .op           (s_operation),
        .pool_entries (pool_entries_reg),
        .rd_addr      (rd_addr),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .dec          (dec)
    );

    // The memory is read only when an item is taken, so the word stays put
    // while a stalled receiver keeps the item in the execute state.
    fisa_stack_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_handle),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_entries_reg <= fisa_pkg::POOL_ENTRIES_RESET;
            entry_stride_reg <= fisa_pkg::ENTRY_STRIDE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fisa_pkg::CFG_POOL_ENTRIES: begin
                    pool_entries_reg <= cfg_data[fisa_pkg::HEAD_W-1:0];
                end
                fisa_pkg::CFG_ENTRY_STRIDE: begin
                    entry_stride_reg <= cfg_data[fisa_pkg::STRIDE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item; the stride product is registered here so the result
    // stage only selects.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg        <= s_operation;
            handle_ok_reg <= (s_handle != fisa_pkg::INVALID_HANDLE);
            prod_reg      <= fisa_pkg::OFFSET_W'(s_handle)
                           * fisa_pkg::OFFSET_W'(entry_stride_reg);
            idx_reg       <= rd_addr;
            dec_reg       <= dec;
        end
    end

    // A popped entry that was never rewritten since the last refill still
    // holds its own index, so the memory word is only used below the mark.
    always_comb begin
        granted_next = fisa_pkg::INVALID_HANDLE;
        if (dec_reg.pop) begin
            granted_next = dec_reg.fresh ? fisa_pkg::HANDLE_W'(idx_reg) : rd_data;
        end
        ovalid_next = (op_reg == fisa_pkg::OP_ACCESS) && handle_ok_reg;
        offset_next = ovalid_next ? prod_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            granted_reg <= granted_next;
            offset_reg  <= offset_next;
            ovalid_reg  <= ovalid_next;
            status_reg  <= dec_reg.status;
            count_reg   <= dec_reg.count;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_granted_handle = granted_reg;
    assign m_byte_offset    = offset_reg;
    assign m_offset_valid   = ovalid_reg;
    assign m_status         = status_reg;
    assign m_in_use_count   = count_reg;

endmodule

// ----- src/fisa_checker.sv -----
module fisa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [fisa_pkg::HANDLE_W-1:0]   m_granted_handle,
    input logic [fisa_pkg::OFFSET_W-1:0]   m_byte_offset,
    input logic                            m_offset_valid,
    input logic [fisa_pkg::STATUS_W-1:0]   m_status,
    input logic [fisa_pkg::HEAD_W-1:0]     m_in_use_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_handle)
                                && $stable(m_in_use_count))
        else $error("result item changed while stalled");

    a_empty_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fisa_pkg::STATUS_EMPTY)
        |-> (m_granted_handle == fisa_pkg::INVALID_HANDLE) && !m_offset_valid)
        else $error("empty obtain granted a handle");

    a_underflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fisa_pkg::STATUS_UNDERFLOW) |-> (m_in_use_count == '0))
        else $error("underflow reported with handles outstanding");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_in_use_count <= fisa_pkg::HEAD_W'(fisa_pkg::POOL_DEPTH)))
        else $error("in-use count exceeds pool depth");

    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_offset_valid |-> (m_byte_offset == '0))
        else $error("offset given without a valid access");

endmodule

bind free_index_stack_allocator fisa_checker u_fisa_checker (.*);
